FILE: rtl/bprm_pkg.sv
// Shared types and constants for the block peak and RMS meter.
// No dependencies; used by bprm_divsqrt and block_peak_rms_meter_core.
package bprm_pkg;

    // Register index codes of the configuration port
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BYPASS = 1'b0;
    localparam t_cfg_idx CFG_MONO   = 1'b1;

    // Accumulator and result widths
    localparam int SUM_BITS = 58;
    localparam int OUT_BITS = 24;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // Shared subtractor width and iteration counts
    localparam int SUB_BITS   = 32;
    localparam int ROOT_BITS  = SUM_BITS / 2;
    localparam int SREM_BITS  = ROOT_BITS + 1;
    localparam int STEP_BITS  = 6;
    localparam int DIV_STEPS  = SUM_BITS;
    localparam int SQRT_STEPS = ROOT_BITS;

endpackage

FILE: rtl/bprm_divsqrt.sv
// Iterative mean-square divider followed by a digit-by-digit square root.
// One subtractor is shared by both phases. Depends on bprm_pkg.
module bprm_divsqrt #(
    parameter int CW = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bprm_pkg::SUM_BITS-1:0]  i_sum,
    input  logic [CW-1:0]                  i_count,
    output logic                           o_done,
    output logic [bprm_pkg::OUT_BITS-1:0]  o_root
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_DIV  = 3'b010,
        D_SQRT = 3'b100
    } t_dstate;

    t_dstate                          r_state;
    logic                             r_done;
    logic [bprm_pkg::STEP_BITS-1:0]   r_step;
    logic [bprm_pkg::SUM_BITS-1:0]    r_work;
    logic [CW-1:0]                    r_rem;
    logic [CW-1:0]                    r_divisor;
    logic [bprm_pkg::SREM_BITS-1:0]   r_srem;
    logic [bprm_pkg::ROOT_BITS-1:0]   r_root;
    logic                             r_zero;

    logic [CW:0]                      div_shift;
    logic [bprm_pkg::SUB_BITS-1:0]    sqrt_shift;
    logic [bprm_pkg::SUB_BITS-1:0]    sub_a;
    logic [bprm_pkg::SUB_BITS-1:0]    sub_b;
    logic [bprm_pkg::SUB_BITS:0]      sub_y;
    logic                             borrow;

    // Operands of the shared subtractor
    assign div_shift  = {r_rem, r_work[bprm_pkg::SUM_BITS-1]};
    assign sqrt_shift = {r_srem, r_work[bprm_pkg::SUM_BITS-1 -: 2]};

    always_comb begin
        case (r_state)
            D_DIV: begin
                sub_a = bprm_pkg::SUB_BITS'(div_shift);
                sub_b = bprm_pkg::SUB_BITS'(r_divisor);
            end
            D_SQRT: begin
                sub_a = sqrt_shift;
                sub_b = bprm_pkg::SUB_BITS'({r_root, 2'b01});
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_y  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = sub_y[bprm_pkg::SUB_BITS];

    // Sequencer: divide, then take the root of the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_DIV;
                        r_step  <= '0;
                    end
                end
                D_DIV: begin
                    if (r_step == bprm_pkg::STEP_BITS'(bprm_pkg::DIV_STEPS - 1)) begin
                        r_state <= D_SQRT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + bprm_pkg::STEP_BITS'(1);
                    end
                end
                D_SQRT: begin
                    if (r_step == bprm_pkg::STEP_BITS'(bprm_pkg::SQRT_STEPS - 1)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_step <= r_step + bprm_pkg::STEP_BITS'(1);
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    // Datapath: shift the work word, keep remainder and root
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_work    <= i_sum;
                    r_rem     <= '0;
                    r_divisor <= i_count;
                    r_srem    <= '0;
                    r_root    <= '0;
                    r_zero    <= (i_count == '0);
                end
            end
            D_DIV: begin
                r_work <= {r_work[bprm_pkg::SUM_BITS-2:0], ~borrow};
                r_rem  <= borrow ? div_shift[CW-1:0] : sub_y[CW-1:0];
            end
            D_SQRT: begin
                r_work <= {r_work[bprm_pkg::SUM_BITS-3:0], 2'b00};
                if (!borrow) begin
                    r_srem <= sub_y[bprm_pkg::SREM_BITS-1:0];
                    r_root <= {r_root[bprm_pkg::ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_srem <= sqrt_shift[bprm_pkg::SREM_BITS-1:0];
                    r_root <= {r_root[bprm_pkg::ROOT_BITS-2:0], 1'b0};
                end
            end
            default: begin
                r_work <= r_work;
            end
        endcase
    end

    // Zero count gives zero; clamp the root to the output width
    assign o_done = r_done;
    always_comb begin
        if (r_zero) begin
            o_root = '0;
        end else if (r_root > bprm_pkg::ROOT_BITS'(bprm_pkg::OUT_MAX)) begin
            o_root = bprm_pkg::OUT_MAX;
        end else begin
            o_root = r_root[bprm_pkg::OUT_BITS-1:0];
        end
    end

endmodule

FILE: rtl/block_peak_rms_meter_core.sv
// Block peak and RMS meter for stereo frames: top level.
// Depends on bprm_pkg and bprm_divsqrt.
//
// Usage: each input beat is one stereo frame (i_sample_left, i_sample_right,
// i_last_of_block) on i_in_valid / o_in_stall. Peaks, sums of squares and a
// frame count are kept per block; the frame flagged last produces one output
// beat on o_out_valid / i_out_stall with both peaks and both RMS values, and
// clears the accumulators. Configuration (bypass, mono_input) is written on
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. A measured frame
// is accepted, then squared and added per channel through one multiplier and
// one saturating adder; o_in_stall holds off the next frame until it is
// through. A last frame then runs the shared divide/square-root unit per
// channel (58 divide steps, 29 root steps, a start state each) and loads
// the output register. A bypassed frame skips peaks and sums, and if last goes
// straight to the output. A frame past the block limit skips only the sums.
// The output register holds a result until it is taken; the next frame is
// accepted meanwhile, and only a new result waits for the register to free.
// Reset clears the accumulators, the configuration and the output valid.
module block_peak_rms_meter_core #(
    parameter int BLOCK_MAX   = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  bprm_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_right,
    input  logic                                i_last_of_block,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bprm_pkg::OUT_BITS-1:0]       o_peak_left,
    output logic [bprm_pkg::OUT_BITS-1:0]       o_peak_right,
    output logic [bprm_pkg::OUT_BITS-1:0]       o_rms_left,
    output logic [bprm_pkg::OUT_BITS-1:0]       o_rms_right
);

    localparam int CW = $clog2(BLOCK_MAX + 1);
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int AW = (PW + 1 > bprm_pkg::SUM_BITS + 1) ? PW + 1 : bprm_pkg::SUM_BITS + 1;
    localparam int EW = (SAMPLE_BITS > bprm_pkg::OUT_BITS) ? SAMPLE_BITS : bprm_pkg::OUT_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MULL  = 10'b00_0000_0010,
        S_ADDL  = 10'b00_0000_0100,
        S_MULR  = 10'b00_0000_1000,
        S_ADDR  = 10'b00_0001_0000,
        S_DIVL  = 10'b00_0010_0000,
        S_WAITL = 10'b00_0100_0000,
        S_DIVR  = 10'b00_1000_0000,
        S_WAITR = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state                           r_state;
    logic                             r_bypass;
    logic                             r_mono;
    logic [SAMPLE_BITS-1:0]           r_peak_l;
    logic [SAMPLE_BITS-1:0]           r_peak_r;
    logic [bprm_pkg::SUM_BITS-1:0]    r_sum_l;
    logic [bprm_pkg::SUM_BITS-1:0]    r_sum_r;
    logic [CW-1:0]                    r_count;
    logic                             r_last;
    logic                             r_byp;
    logic                             r_out_valid;

    logic [SAMPLE_BITS-1:0]           r_mag_l;
    logic [SAMPLE_BITS-1:0]           r_mag_r;
    logic [PW-1:0]                    r_prod;
    logic [bprm_pkg::OUT_BITS-1:0]    r_rms_l;
    logic [bprm_pkg::OUT_BITS-1:0]    r_rms_r;
    logic [bprm_pkg::OUT_BITS-1:0]    r_o_peak_l;
    logic [bprm_pkg::OUT_BITS-1:0]    r_o_peak_r;
    logic [bprm_pkg::OUT_BITS-1:0]    r_o_rms_l;
    logic [bprm_pkg::OUT_BITS-1:0]    r_o_rms_r;

    logic                             in_take;
    logic                             out_free;
    logic                             do_sum;
    logic [SAMPLE_BITS-1:0]           mag_l;
    logic [SAMPLE_BITS-1:0]           mag_r;
    logic [SAMPLE_BITS-1:0]           mul_op;
    logic [bprm_pkg::SUM_BITS-1:0]    add_sum;
    logic [AW-1:0]                    add_y;
    logic [bprm_pkg::SUM_BITS-1:0]    sat_sum;
    logic [EW-1:0]                    pk_l_ext;
    logic [EW-1:0]                    pk_r_ext;
    logic [bprm_pkg::OUT_BITS-1:0]    pk_l_clamp;
    logic [bprm_pkg::OUT_BITS-1:0]    pk_r_clamp;
    logic                             ds_start;
    logic                             ds_done;
    logic [bprm_pkg::OUT_BITS-1:0]    ds_root;

    // Handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign do_sum     = (r_count < CW'(BLOCK_MAX));

    // Sample magnitudes; mono repeats the left channel
    assign mag_l = i_sample_left[SAMPLE_BITS-1] ?
                   (~i_sample_left + SAMPLE_BITS'(1)) : i_sample_left;
    assign mag_r = r_mono ? mag_l :
                   (i_sample_right[SAMPLE_BITS-1] ?
                    (~i_sample_right + SAMPLE_BITS'(1)) : i_sample_right);

    // Shared squarer and saturating accumulator
    assign mul_op  = (r_state == S_MULR) ? r_mag_r : r_mag_l;
    assign add_sum = (r_state == S_ADDR) ? r_sum_r : r_sum_l;
    assign add_y   = AW'(add_sum) + AW'(r_prod);
    assign sat_sum = (add_y > AW'(bprm_pkg::SUM_MAX)) ? bprm_pkg::SUM_MAX
                                                      : add_y[bprm_pkg::SUM_BITS-1:0];

    // Clamp peaks to the output width
    assign pk_l_ext   = EW'(r_peak_l);
    assign pk_r_ext   = EW'(r_peak_r);
    assign pk_l_clamp = (pk_l_ext > EW'(bprm_pkg::OUT_MAX)) ? bprm_pkg::OUT_MAX
                                                            : pk_l_ext[bprm_pkg::OUT_BITS-1:0];
    assign pk_r_clamp = (pk_r_ext > EW'(bprm_pkg::OUT_MAX)) ? bprm_pkg::OUT_MAX
                                                            : pk_r_ext[bprm_pkg::OUT_BITS-1:0];

    // Divide and root unit, run once per channel
    assign ds_start = (r_state == S_DIVL) || (r_state == S_DIVR);

    bprm_divsqrt #(
        .CW (CW)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ds_start),
        .i_sum   ((r_state == S_DIVR) ? r_sum_r : r_sum_l),
        .i_count (r_count),
        .o_done  (ds_done),
        .o_root  (ds_root)
    );

    // Control, configuration and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bypass    <= 1'b0;
            r_mono      <= 1'b0;
            r_peak_l    <= '0;
            r_peak_r    <= '0;
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_count     <= '0;
            r_last      <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Write configuration
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bprm_pkg::CFG_BYPASS: r_bypass <= i_cfg_data;
                    bprm_pkg::CFG_MONO:   r_mono   <= i_cfg_data;
                    default: ;
                endcase
            end

            // Load the output beat, or drop it once taken
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_last <= i_last_of_block;
                        r_byp  <= r_bypass;
                        if (r_bypass) begin
                            r_state <= i_last_of_block ? S_EMIT : S_IDLE;
                        end else begin
                            if (mag_l > r_peak_l) r_peak_l <= mag_l;
                            if (mag_r > r_peak_r) r_peak_r <= mag_r;
                            if (do_sum) begin
                                r_state <= S_MULL;
                            end else begin
                                r_state <= i_last_of_block ? S_DIVL : S_IDLE;
                            end
                        end
                    end
                end
                S_MULL: r_state <= S_ADDL;
                S_ADDL: begin
                    r_sum_l <= sat_sum;
                    r_state <= S_MULR;
                end
                S_MULR: r_state <= S_ADDR;
                S_ADDR: begin
                    r_sum_r <= sat_sum;
                    r_count <= r_count + CW'(1);
                    r_state <= r_last ? S_DIVL : S_IDLE;
                end
                S_DIVL: r_state <= S_WAITL;
                S_WAITL: begin
                    if (ds_done) r_state <= S_DIVR;
                end
                S_DIVR: r_state <= S_WAITR;
                S_WAITR: begin
                    if (ds_done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Clear for the next block once the result is loaded
                    if (out_free) begin
                        r_peak_l    <= '0;
                        r_peak_r    <= '0;
                        r_sum_l     <= '0;
                        r_sum_r     <= '0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mag_l <= mag_l;
            r_mag_r <= mag_r;
        end
        if ((r_state == S_MULL) || (r_state == S_MULR)) begin
            r_prod <= PW'(mul_op) * PW'(mul_op);
        end
        if ((r_state == S_WAITL) && ds_done) r_rms_l <= ds_root;
        if ((r_state == S_WAITR) && ds_done) r_rms_r <= ds_root;
        if ((r_state == S_EMIT) && out_free) begin
            r_o_peak_l <= r_byp ? '0 : pk_l_clamp;
            r_o_peak_r <= r_byp ? '0 : pk_r_clamp;
            r_o_rms_l  <= r_byp ? '0 : r_rms_l;
            r_o_rms_r  <= r_byp ? '0 : r_rms_r;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_peak_left  = r_o_peak_l;
    assign o_peak_right = r_o_peak_r;
    assign o_rms_left   = r_o_rms_l;
    assign o_rms_right  = r_o_rms_r;

    // Assertions
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BLOCK_MAX))
        else $error("frame count beyond block limit");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && out_free |=>
            (r_count == '0) && (r_sum_l == '0) && (r_peak_r == '0))
        else $error("accumulators not cleared after result");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_done |-> (r_state == S_WAITL) || (r_state == S_WAITR))
        else $error("root unit finished outside a wait state");

    a_rms_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_rms_l <= r_o_peak_l) && (r_o_rms_r <= r_o_peak_r))
        else $error("rms exceeds peak");

endmodule
